### rtl/unique_id_set_table_core_assert.svh
// Assertion macros for the checker of the id set table.
// The macros expect a signal named clk in the using scope; UIDT_ASSERT_RUN also rst_n.
`ifndef UNIQUE_ID_SET_TABLE_CORE_ASSERT_SVH
`define UNIQUE_ID_SET_TABLE_CORE_ASSERT_SVH

// Checked only while the block is out of reset.
`define UIDT_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define UIDT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/uidt_pkg.sv
`default_nettype none
package uidt_pkg;

  localparam int UIDT_CAPACITY = 16;
  localparam int UIDT_ID_BITS  = 32;

  localparam int ACTION_W = 2;
  localparam int ID_W     = 32;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;
  localparam int VALUE_W  = 32;

  localparam logic [ACTION_W-1:0] ACT_ADD  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DEL  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RESERVED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;
    logic                scan_run;
    logic                rd_idx;
    logic                rd_last;
    logic                wr_add;
    logic                wr_move;
    logic                out_load;
    logic [STATUS_W-1:0] out_status;
    logic                out_slot_valid;
  } uidt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                reserved;
    logic                full;
    logic                rd_ok;
    logic                hit;
    logic                scan_done;
    logic                out_busy;
  } uidt_stat_t;

endpackage
`default_nettype wire

### rtl/uidt_if.sv
`default_nettype none
interface uidt_in_if;
  import uidt_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ID_W-1:0]     id;
  logic [INDEX_W-1:0]  index;

  modport source (output valid, output action, output id, output index, input ready);
  modport sink   (input valid, input action, input id, input index, output ready);
endinterface

interface uidt_out_if;
  import uidt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;
  logic [VALUE_W-1:0]  slot_value;
  logic                slot_valid;

  modport source (output valid, output status, output entry_count, output slot_value,
                  output slot_valid, input ready);
  modport sink   (input valid, input status, input entry_count, input slot_value,
                  input slot_valid, output ready);
endinterface
`default_nettype wire

### rtl/uidt_ctrl.sv
`default_nettype none
module uidt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  uidt_pkg::uidt_stat_t stat,
  output uidt_pkg::uidt_cmd_t  cmd
);
  import uidt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_LAST   = 3'd3;
  localparam logic [2:0] S_MOVE   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                slotv_r, slotv_nxt;

  always_comb begin
    cmd            = '0;
    state_nxt      = state_r;
    status_nxt     = status_r;
    slotv_nxt      = slotv_r;
    in_ready       = (state_r == S_IDLE);
    cmd.out_status = status_r;
    cmd.out_slot_valid = slotv_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          status_nxt = ST_OK;
          slotv_nxt  = 1'b0;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.action) inside
          ACT_ADD, ACT_DEL: begin
            if (stat.reserved) begin
              status_nxt = ST_RESERVED;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          ACT_READ: begin
            if (stat.rd_ok) begin
              cmd.rd_idx = 1'b1;
              slotv_nxt  = 1'b1;
            end
            state_nxt = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.hit) begin
          if (stat.action == ACT_ADD) begin
            status_nxt = ST_DUP;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_LAST;
          end
        end else if (stat.scan_done) begin
          if (stat.action == ACT_ADD) begin
            if (stat.full) begin
              status_nxt = ST_FULL;
            end else begin
              cmd.wr_add = 1'b1;
            end
          end else begin
            status_nxt = ST_NOTFOUND;
          end
          state_nxt = S_DONE;
        end
      end
      S_LAST: begin
        cmd.rd_last = 1'b1;
        state_nxt   = S_MOVE;
      end
      S_MOVE: begin
        // The last entry fills the slot of the deleted id.
        cmd.wr_move = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_OK;
      slotv_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      slotv_r  <= slotv_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/uidt_datapath.sv
`default_nettype none
module uidt_datapath #(
  parameter int CAPACITY = uidt_pkg::UIDT_CAPACITY,
  parameter int ID_BITS  = uidt_pkg::UIDT_ID_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [uidt_pkg::ACTION_W-1:0]   in_action,
  input  logic [uidt_pkg::ID_W-1:0]       in_id,
  input  logic [uidt_pkg::INDEX_W-1:0]    in_index,
  input  uidt_pkg::uidt_cmd_t             cmd,
  output uidt_pkg::uidt_stat_t            stat,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [uidt_pkg::STATUS_W-1:0]   out_status,
  output logic [uidt_pkg::COUNT_W-1:0]    out_entry_count,
  output logic [uidt_pkg::VALUE_W-1:0]    out_slot_value,
  output logic                            out_slot_valid
);
  import uidt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [ACTION_W-1:0] act_r;
  logic [ID_BITS-1:0]  id_r;
  logic [INDEX_W-1:0]  idx_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       scan_ptr_r;
  logic [AW-1:0]       pos_r;

  logic [ID_BITS-1:0]  mem [CAPACITY];
  logic [ID_BITS-1:0]  rd_data_r;
  logic [AW-1:0]       rd_idx_r;
  logic                rd_vld_r;

  logic [STATUS_W-1:0] out_status_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic [VALUE_W-1:0]  out_value_r;
  logic                out_slotv_r;
  logic                out_valid_r;

  logic                scan_issue;
  logic                scan_rd;
  logic                hit;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [ID_BITS-1:0]  wr_data;

  assign scan_issue = (scan_ptr_r < count_r);
  assign scan_rd    = cmd.scan_run && scan_issue;
  assign hit        = rd_vld_r && (rd_data_r == id_r);

  always_comb begin
    rd_en = cmd.rd_idx || cmd.rd_last || scan_rd;
    if (cmd.rd_idx) begin
      rd_addr = AW'(idx_r);
    end else if (cmd.rd_last) begin
      rd_addr = AW'(count_r - CW'(1));
    end else begin
      rd_addr = scan_ptr_r[AW-1:0];
    end
  end

  assign wr_en   = cmd.wr_add || cmd.wr_move;
  assign wr_addr = cmd.wr_add ? count_r[AW-1:0] : pos_r;
  assign wr_data = cmd.wr_add ? id_r : rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_idx_r  <= rd_addr;
    end
  end

  // Input transaction payload, and the slot position of a scan match.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      id_r  <= ID_BITS'(in_id);
      idx_r <= in_index;
    end
    if (cmd.scan_run && hit) begin
      pos_r <= rd_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      scan_ptr_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      rd_vld_r <= scan_rd;
      if (cmd.load) begin
        scan_ptr_r <= '0;
      end else if (scan_rd) begin
        scan_ptr_r <= scan_ptr_r + CW'(1);
      end
      if (cmd.wr_add) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.wr_move) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_comb begin
    stat.action    = act_r;
    stat.reserved  = (id_r == '1);
    stat.full      = (count_r == CAP_CNT);
    stat.rd_ok     = (32'(idx_r) < 32'(CAPACITY)) && (32'(idx_r) < 32'(count_r));
    stat.hit       = hit;
    stat.scan_done = !rd_vld_r && !scan_issue;
    stat.out_busy  = out_valid_r && !out_ready;
  end

  // Output register: a finished result waits here until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_count_r  <= COUNT_W'(count_r);
      out_value_r  <= cmd.out_slot_valid ? VALUE_W'(rd_data_r) : '0;
      out_slotv_r  <= cmd.out_slot_valid;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_slot_value  = out_value_r;
  assign out_slot_valid  = out_slotv_r;

endmodule
`default_nettype wire

### rtl/unique_id_set_table_core.sv
`default_nettype none
// Fixed-capacity set of distinct ids, kept packed in slots 0 to count-1 of a
// single-port-read memory. Add and delete scan the held entries one per cycle
// through the memory read port. An add that finds no match, or a delete that
// misses, reads every held entry before it ends. A match at slot p ends the
// scan there; an add then reports a duplicate, and a delete moves the last
// entry into the freed slot. A read or a rejected reserved id needs no scan.
// Results leave through an output register, so a waiting result only stalls
// the block when the next one is ready to go out. The memory needs no
// clearing after reset: slots at or above the count are never returned.
module unique_id_set_table_core #(
  parameter int CAPACITY = uidt_pkg::UIDT_CAPACITY,
  parameter int ID_BITS  = uidt_pkg::UIDT_ID_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  uidt_in_if.sink    in_ch,
  uidt_out_if.source out_ch
);
  import uidt_pkg::*;

  uidt_cmd_t  cmd;
  uidt_stat_t stat;
  logic       in_ready;

  uidt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  uidt_datapath #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_ch.action),
    .in_id           (in_ch.id),
    .in_index        (in_ch.index),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_entry_count (out_ch.entry_count),
    .out_slot_value  (out_ch.slot_value),
    .out_slot_valid  (out_ch.slot_valid)
  );

  assign in_ch.ready = in_ready;

endmodule
`default_nettype wire

### rtl/uidt_checker.sv
`default_nettype none
`include "unique_id_set_table_core_assert.svh"
module uidt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [uidt_pkg::STATUS_W-1:0] out_status,
  input logic [uidt_pkg::COUNT_W-1:0]  out_entry_count,
  input logic [uidt_pkg::VALUE_W-1:0]  out_slot_value,
  input logic                          out_slot_valid
);
  import uidt_pkg::*;

  // A stalled result must not change.
  `UIDT_ASSERT_RUN(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_entry_count) && $stable(out_slot_value) && $stable(out_slot_valid), "result changed while stalled")

  `UIDT_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && in_ready, "block not idle after reset")

  // Items are worked one at a time, so input is closed right after a transaction.
  `UIDT_ASSERT_RUN(a_one_item, in_valid && in_ready |=> !in_ready, "second item accepted while busy")

  // Only a successful read carries a slot value.
  `UIDT_ASSERT_RUN(a_slot_ok, out_valid && (out_slot_valid || out_slot_value != '0) |-> out_slot_valid && out_status == ST_OK, "slot value without a valid read")

endmodule

bind unique_id_set_table_core uidt_checker u_uidt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_entry_count (out_ch.entry_count),
  .out_slot_value  (out_ch.slot_value),
  .out_slot_valid  (out_ch.slot_valid)
);
`default_nettype wire
